>>> rtl/grw_pkg.sv
// Shared types, command codes and helper functions for the grid robot world sensors unit.
package grw_pkg;

   // Field widths and packed channel widths
   localparam int REQ_W  = 48;   // 46 payload bits padded to whole bytes
   localparam int RSP_W  = 24;   // 18 payload bits padded to whole bytes
   localparam int CFG_W  = 7;
   localparam int CRD_W  = 12;   // walking coordinate, signed
   localparam int DIST_W = 11;   // running scan distance, cm

   // Command codes
   localparam logic [3:0] CMD_OBSTACLE  = 4'd0;
   localparam logic [3:0] CMD_LINE      = 4'd1;
   localparam logic [3:0] CMD_ROBOT     = 4'd2;
   localparam logic [3:0] CMD_TARGET    = 4'd3;
   localparam logic [3:0] CMD_MOVE_TGT  = 4'd4;
   localparam logic [3:0] CMD_STEP      = 4'd5;
   localparam logic [3:0] CMD_ROTATE    = 4'd6;
   localparam logic [3:0] CMD_RAYCAST   = 4'd7;
   localparam logic [3:0] CMD_LINE_SNS  = 4'd8;
   localparam logic [3:0] CMD_TGT_SNS   = 4'd9;

   // Look directions
   localparam logic [1:0] LOOK_LEFT  = 2'd0;
   localparam logic [1:0] LOOK_RIGHT = 2'd2;

   // Register indexes
   localparam logic [0:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_GRID_HEIGHT = 1'b1;

   localparam logic [2:0] LINE_TAPS   = 3'd5;
   localparam logic [6:0] SENSE_SQ    = 7'd36;
   localparam logic [8:0] SENSE_RANGE = 9'd6;

   // Map access request from the sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_obst;
      logic wr_line;
   } map_req_type;

   // Column step for a heading: north 0, east +1, south 0, west -1
   function automatic logic signed [1:0] dir_col(input logic [1:0] h);
      case (h)
         2'd1:    dir_col = 2'sd1;
         2'd3:    dir_col = -2'sd1;
         default: dir_col = 2'sd0;
      endcase
   endfunction

   // Row step for a heading: north -1, south +1
   function automatic logic signed [1:0] dir_row(input logic [1:0] h);
      case (h)
         2'd0:    dir_row = -2'sd1;
         2'd2:    dir_row = 2'sd1;
         default: dir_row = 2'sd0;
      endcase
   endfunction

   // Square of a value 0..7
   function automatic logic [5:0] sq3(input logic [2:0] v);
      case (v)
         3'd0:    sq3 = 6'd0;
         3'd1:    sq3 = 6'd1;
         3'd2:    sq3 = 6'd4;
         3'd3:    sq3 = 6'd9;
         3'd4:    sq3 = 6'd16;
         3'd5:    sq3 = 6'd25;
         3'd6:    sq3 = 6'd36;
         default: sq3 = 6'd49;
      endcase
   endfunction

endpackage

>>> rtl/grid_robot_world_sensors_unit.sv
// Top level of the grid robot world sensors unit: sequencer, robot state and result register.
// Each item is latched on its input transfer and run by the sequencer to a result. Raycast walks
// its ray through the one map read port a cell a cycle, at most SCAN_MAX_CM/CELL_CM cells.
// One item in work at a time: a new one is taken only after the last result has entered the
// output register, later while rsp_tready holds the previous result. Reset is synchronous and
// clears state at once; a clearing pass then zeroes both maps, req_tready low.
module grid_robot_world_sensors_unit #(
   parameter int MAX_COLS    = 64,
   parameter int MAX_ROWS    = 64,
   parameter int CELL_CM     = 10,
   parameter int SCAN_MAX_CM = 200
) (
   input  logic                        clock,
   input  logic                        reset,
   // cmd[3:0] pos_x[11:4] pos_y[19:12] heading_in[21:20] step_sign[23:22]
   // turn_count[27:24] look_dir[29:28] move_dx[37:30] move_dy[45:38]
   input  logic [grw_pkg::REQ_W-1:0]   req_tdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // ok[0] distance_cm[10:1] line_bits[15:11] target_left[16] target_right[17]
   output logic [grw_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic                        csr_wr_en,
   input  logic [0:0]                  csr_index,
   input  logic [grw_pkg::CFG_W-1:0]   csr_wdata
);

   localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ADDR_W     = COL_W + ROW_W;
   localparam int SCAN_LIMIT = (SCAN_MAX_CM / CELL_CM) * CELL_CM;
   localparam int CW         = grw_pkg::CRD_W;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_EXEC  = 9'b000000100,
      S_MARK  = 9'b000001000,
      S_TEST  = 9'b000010000,
      S_CHECK = 9'b000100000,
      S_SCAN  = 9'b001000000,
      S_LINE  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   function automatic logic signed [CW-1:0] ext8(input logic [7:0] v);
      ext8 = {{(CW-8){v[7]}}, v};
   endfunction

   function automatic logic signed [CW-1:0] ext2(input logic [1:0] v);
      ext2 = {{(CW-2){v[1]}}, v};
   endfunction

   state_type state_ff, state_in;

   // Configuration registers
   logic [grw_pkg::CFG_W-1:0] width_ff, height_ff, cols_used, rows_used;

   // Latched item
   logic [3:0] cmd_ff;
   logic [7:0] pos_x_ff, pos_y_ff, move_dx_ff, move_dy_ff;
   logic [1:0] heading_in_ff, step_sign_ff, look_dir_ff;
   logic [3:0] turn_count_ff;

   // World state
   logic [7:0] robot_col_ff, robot_col_in, robot_row_ff, robot_row_in;
   logic [7:0] target_col_ff, target_col_in, target_row_ff, target_row_in;
   logic [1:0] heading_ff, heading_in;
   logic       tvalid_ff, tvalid_in;

   // Walk and scan registers
   logic signed [CW-1:0]     walk_col_ff, walk_col_in, walk_row_ff, walk_row_in;
   logic [1:0]               dcol_ff, dcol_in, drow_ff, drow_in;
   logic [grw_pkg::DIST_W-1:0] scan_cm_ff, scan_cm_in;
   logic                     pend_ff, pend_in, pend_ok_ff, pend_ok_in;
   logic [2:0]               pend_idx_ff, pend_idx_in, idx_ff, idx_in;

   // Result under construction and output register
   logic       ok_ff, ok_in, tl_ff, tl_in, tr_ff, tr_in;
   logic [9:0] dist_ff, dist_in;
   logic [4:0] lines_ff, lines_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [grw_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // Map and probe
   grw_pkg::map_req_type map_req;
   logic [ADDR_W-1:0]    map_addr;
   logic                 rd_obst, rd_line, clear_busy, on_grid;

   // Target sense terms
   logic signed [9:0] ddx, ddy, fwd, lat;
   logic [8:0]        adx, ady;
   logic              near;

   // Start-point helpers
   logic [1:0]           h_look, h_side;
   logic signed [1:0]    sc, sr;
   logic signed [CW-1:0] add_col, add_row;

   assign cols_used = (width_ff < grw_pkg::CFG_W'(MAX_COLS)) ? width_ff
                                                             : grw_pkg::CFG_W'(MAX_COLS);
   assign rows_used = (height_ff < grw_pkg::CFG_W'(MAX_ROWS)) ? height_ff
                                                              : grw_pkg::CFG_W'(MAX_ROWS);

   grw_probe #(.COL_W(COL_W), .ROW_W(ROW_W)) u_probe (
      .col       (walk_col_ff),
      .row       (walk_row_ff),
      .cols_used (cols_used),
      .rows_used (rows_used),
      .on_grid   (on_grid),
      .addr      (map_addr)
   );

   grw_map #(.ADDR_W(ADDR_W)) u_map (
      .clock      (clock),
      .reset      (reset),
      .req        (map_req),
      .addr       (map_addr),
      .rd_obst    (rd_obst),
      .rd_line    (rd_line),
      .clear_busy (clear_busy)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Target sense geometry: forward and lateral offsets in the robot's frame
   always_comb begin
      ddx = 10'(signed'({target_col_ff[7], target_col_ff}) -
                signed'({robot_col_ff[7], robot_col_ff}));
      ddy = 10'(signed'({target_row_ff[7], target_row_ff}) -
                signed'({robot_row_ff[7], robot_row_ff}));
      case (heading_ff)
         2'd0:    begin fwd = -ddy; lat = ddx;  end
         2'd1:    begin fwd = ddx;  lat = ddy;  end
         2'd2:    begin fwd = ddy;  lat = -ddx; end
         default: begin fwd = -ddx; lat = -ddy; end
      endcase
      adx  = ddx[9] ? 9'(-ddx) : ddx[8:0];
      ady  = ddy[9] ? 9'(-ddy) : ddy[8:0];
      near = (adx <= grw_pkg::SENSE_RANGE) && (ady <= grw_pkg::SENSE_RANGE) &&
             ({1'b0, grw_pkg::sq3(adx[2:0])} + {1'b0, grw_pkg::sq3(ady[2:0])}
              <= grw_pkg::SENSE_SQ);
   end

   // Shared walk adder: advance the probe coordinate by one cell
   assign add_col = walk_col_ff + ext2(dcol_ff);
   assign add_row = walk_row_ff + ext2(drow_ff);

   always_comb begin
      state_in      = state_ff;
      robot_col_in  = robot_col_ff;
      robot_row_in  = robot_row_ff;
      heading_in    = heading_ff;
      tvalid_in     = tvalid_ff;
      target_col_in = target_col_ff;
      target_row_in = target_row_ff;
      walk_col_in   = walk_col_ff;
      walk_row_in   = walk_row_ff;
      dcol_in       = dcol_ff;
      drow_in       = drow_ff;
      scan_cm_in    = scan_cm_ff;
      pend_in       = pend_ff;
      pend_ok_in    = pend_ok_ff;
      pend_idx_in   = pend_idx_ff;
      idx_in        = idx_ff;
      ok_in         = ok_ff;
      dist_in       = dist_ff;
      lines_in      = lines_ff;
      tl_in         = tl_ff;
      tr_in         = tr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      map_req       = '0;
      h_look        = heading_ff;
      h_side        = heading_ff + 2'd1;
      sc            = grw_pkg::dir_col(heading_ff);
      sr            = grw_pkg::dir_row(heading_ff);

      case (state_ff)
         S_CLEAR: begin
            if (!clear_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            ok_in    = 1'b1;
            dist_in  = '0;
            lines_in = '0;
            tl_in    = 1'b0;
            tr_in    = 1'b0;
            pend_in  = 1'b0;
            state_in = S_DONE;
            case (cmd_ff)
               grw_pkg::CMD_OBSTACLE, grw_pkg::CMD_LINE: begin
                  walk_col_in = ext8(pos_x_ff);
                  walk_row_in = ext8(pos_y_ff);
                  state_in    = S_MARK;
               end
               grw_pkg::CMD_ROBOT: begin
                  robot_col_in = pos_x_ff;
                  robot_row_in = pos_y_ff;
                  heading_in   = heading_in_ff;
               end
               grw_pkg::CMD_TARGET: begin
                  tvalid_in     = 1'b1;
                  target_col_in = pos_x_ff;
                  target_row_in = pos_y_ff;
               end
               grw_pkg::CMD_MOVE_TGT: begin
                  walk_col_in = ext8(target_col_ff) + ext8(move_dx_ff);
                  walk_row_in = ext8(target_row_ff) + ext8(move_dy_ff);
                  if (tvalid_ff) begin
                     state_in = S_TEST;
                  end
               end
               grw_pkg::CMD_STEP: begin
                  // Zero stays, -1 and -2 step back, +1 steps forward
                  if (step_sign_ff == 2'b00) begin
                     sc = 2'sd0;
                     sr = 2'sd0;
                  end else if (step_sign_ff[1]) begin
                     sc = -grw_pkg::dir_col(heading_ff);
                     sr = -grw_pkg::dir_row(heading_ff);
                  end
                  walk_col_in = ext8(robot_col_ff) + ext2(sc);
                  walk_row_in = ext8(robot_row_ff) + ext2(sr);
                  state_in    = S_TEST;
               end
               grw_pkg::CMD_ROTATE: begin
                  heading_in = heading_ff + turn_count_ff[1:0];
               end
               grw_pkg::CMD_RAYCAST: begin
                  if (look_dir_ff == grw_pkg::LOOK_LEFT) begin
                     h_look = heading_ff + 2'd3;
                  end else if (look_dir_ff == grw_pkg::LOOK_RIGHT) begin
                     h_look = heading_ff + 2'd1;
                  end
                  sc          = grw_pkg::dir_col(h_look);
                  sr          = grw_pkg::dir_row(h_look);
                  dcol_in     = sc;
                  drow_in     = sr;
                  walk_col_in = ext8(robot_col_ff) + ext2(sc);
                  walk_row_in = ext8(robot_row_ff) + ext2(sr);
                  scan_cm_in  = grw_pkg::DIST_W'(CELL_CM);
                  state_in    = S_SCAN;
               end
               grw_pkg::CMD_LINE_SNS: begin
                  sc          = grw_pkg::dir_col(h_side);
                  sr          = grw_pkg::dir_row(h_side);
                  dcol_in     = sc;
                  drow_in     = sr;
                  walk_col_in = ext8(robot_col_ff) - (ext2(sc) <<< 1);
                  walk_row_in = ext8(robot_row_ff) - (ext2(sr) <<< 1);
                  idx_in      = '0;
                  state_in    = S_LINE;
               end
               grw_pkg::CMD_TGT_SNS: begin
                  if (tvalid_ff && !fwd[9] && near) begin
                     tl_in = (lat <= 10'sd1);
                     tr_in = (lat >= -10'sd1);
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_MARK: begin
            map_req.wr_obst = on_grid && (cmd_ff == grw_pkg::CMD_OBSTACLE);
            map_req.wr_line = on_grid && (cmd_ff == grw_pkg::CMD_LINE);
            state_in        = S_DONE;
         end
         S_TEST: begin
            if (on_grid) begin
               map_req.rd_en = 1'b1;
               state_in      = S_CHECK;
            end else begin
               ok_in    = (cmd_ff != grw_pkg::CMD_STEP);
               state_in = S_DONE;
            end
         end
         S_CHECK: begin
            if (rd_obst) begin
               ok_in = (cmd_ff != grw_pkg::CMD_STEP);
            end else if (cmd_ff == grw_pkg::CMD_STEP) begin
               robot_col_in = walk_col_ff[7:0];
               robot_row_in = walk_row_ff[7:0];
            end else begin
               target_col_in = walk_col_ff[7:0];
               target_row_in = walk_row_ff[7:0];
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            // Check the previous cell's read while issuing the next one
            if (pend_ff && rd_obst) begin
               dist_in  = 10'(scan_cm_ff - grw_pkg::DIST_W'(CELL_CM));
               state_in = S_DONE;
            end else if (scan_cm_ff > grw_pkg::DIST_W'(SCAN_LIMIT)) begin
               dist_in  = 10'(SCAN_MAX_CM);
               state_in = S_DONE;
            end else if (!on_grid) begin
               dist_in  = scan_cm_ff[9:0];
               state_in = S_DONE;
            end else begin
               map_req.rd_en = 1'b1;
               pend_in       = 1'b1;
               scan_cm_in    = scan_cm_ff + grw_pkg::DIST_W'(CELL_CM);
               walk_col_in   = add_col;
               walk_row_in   = add_row;
            end
         end
         S_LINE: begin
            if (pend_ff && pend_ok_ff && rd_line) begin
               lines_in[pend_idx_ff] = 1'b1;
            end
            if (idx_ff == grw_pkg::LINE_TAPS) begin
               pend_in  = 1'b0;
               state_in = S_DONE;
            end else begin
               map_req.rd_en = on_grid;
               pend_in       = 1'b1;
               pend_ok_in    = on_grid;
               pend_idx_in   = idx_ff;
               idx_in        = idx_ff + 3'd1;
               walk_col_in   = add_col;
               walk_row_in   = add_row;
            end
         end
         S_DONE: begin
            // Hold the result until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = grw_pkg::RSP_W'({tr_ff, tl_ff, lines_ff, dist_ff, ok_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and world state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         width_ff      <= 7'd64;
         height_ff     <= 7'd64;
         robot_col_ff  <= '0;
         robot_row_ff  <= '0;
         heading_ff    <= '0;
         tvalid_ff     <= 1'b0;
         target_col_ff <= '0;
         target_row_ff <= '0;
         pend_ff       <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         robot_col_ff  <= robot_col_in;
         robot_row_ff  <= robot_row_in;
         heading_ff    <= heading_in;
         tvalid_ff     <= tvalid_in;
         target_col_ff <= target_col_in;
         target_row_ff <= target_row_in;
         pend_ff       <= pend_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               grw_pkg::CSR_GRID_WIDTH:  width_ff  <= csr_wdata;
               grw_pkg::CSR_GRID_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff        <= req_tdata[3:0];
         pos_x_ff      <= req_tdata[11:4];
         pos_y_ff      <= req_tdata[19:12];
         heading_in_ff <= req_tdata[21:20];
         step_sign_ff  <= req_tdata[23:22];
         turn_count_ff <= req_tdata[27:24];
         look_dir_ff   <= req_tdata[29:28];
         move_dx_ff    <= req_tdata[37:30];
         move_dy_ff    <= req_tdata[45:38];
      end
      walk_col_ff <= walk_col_in;
      walk_row_ff <= walk_row_in;
      dcol_ff     <= dcol_in;
      drow_ff     <= drow_in;
      scan_cm_ff  <= scan_cm_in;
      pend_ok_ff  <= pend_ok_in;
      pend_idx_ff <= pend_idx_in;
      ok_ff       <= ok_in;
      dist_ff     <= dist_in;
      lines_ff    <= lines_in;
      tl_ff       <= tl_in;
      tr_ff       <= tr_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("sequencer state not one-hot");
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_tready)
      else $error("input accepted during map clearing pass");
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EXEC))
      else $error("accepted transfer not executed");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_cm_ff <= grw_pkg::DIST_W'(SCAN_LIMIT + CELL_CM)))
      else $error("raycast walked past its range");
`endif

endmodule

>>> rtl/grw_map.sv
// Obstacle and line bit maps with registered read and a clearing pass after reset.
module grw_map #(
   parameter int ADDR_W = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  grw_pkg::map_req_type     req,
   input  logic [ADDR_W-1:0]        addr,
   output logic                     rd_obst,
   output logic                     rd_line,
   output logic                     clear_busy
);

   localparam int DEPTH = 1 << ADDR_W;

   logic obst_mem [DEPTH];
   logic line_mem [DEPTH];

   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              busy_ff, busy_in;

   always_comb begin
      clr_cnt_in = clr_cnt_ff + 1'b1;
      busy_in    = busy_ff && (clr_cnt_ff != {ADDR_W{1'b1}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         busy_ff    <= 1'b1;
      end else if (busy_ff) begin
         clr_cnt_ff <= clr_cnt_in;
         busy_ff    <= busy_in;
      end
   end

   // Sweep zeros during the clearing pass, otherwise set marked cells
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         obst_mem[clr_cnt_ff] <= 1'b0;
         line_mem[clr_cnt_ff] <= 1'b0;
      end else begin
         if (req.wr_obst) begin
            obst_mem[addr] <= 1'b1;
         end
         if (req.wr_line) begin
            line_mem[addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_obst <= obst_mem[addr];
         rd_line <= line_mem[addr];
      end
   end

   assign clear_busy = busy_ff;

endmodule

>>> rtl/grw_probe.sv
// Bounds check and map address for one grid coordinate.
module grw_probe #(
   parameter int COL_W = 6,
   parameter int ROW_W = 6
) (
   input  logic signed [grw_pkg::CRD_W-1:0] col,
   input  logic signed [grw_pkg::CRD_W-1:0] row,
   input  logic [grw_pkg::CFG_W-1:0]        cols_used,
   input  logic [grw_pkg::CFG_W-1:0]        rows_used,
   output logic                             on_grid,
   output logic [COL_W+ROW_W-1:0]           addr
);

   logic col_ok, row_ok;

   always_comb begin
      col_ok  = !col[grw_pkg::CRD_W-1] &&
                ($unsigned(col) < grw_pkg::CRD_W'(cols_used));
      row_ok  = !row[grw_pkg::CRD_W-1] &&
                ($unsigned(row) < grw_pkg::CRD_W'(rows_used));
      on_grid = col_ok && row_ok;
      addr    = {row[ROW_W-1:0], col[COL_W-1:0]};
   end

endmodule

>>> test/testbench.sv
// Self-checking testbench for the grid robot world sensors unit.
module testbench;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int CELL_CM = 10;
   localparam int SCAN_MAX_CM = 200;
   localparam int SENSE_RANGE_I = 6;

   typedef struct packed {
      logic [3:0] cmd;
      logic signed [7:0] pos_x;
      logic signed [7:0] pos_y;
      logic [1:0] heading_in;
      logic signed [1:0] step_sign;
      logic signed [3:0] turn_count;
      logic [1:0] look_dir;
      logic signed [7:0] move_dx;
      logic signed [7:0] move_dy;
   } world_cmd_type;

   // Highest bit first, so ok lands in bit 0 as on rsp_tdata
   typedef struct packed {
      logic target_right;
      logic target_left;
      logic [4:0] line_bits;
      logic [9:0] distance_cm;
      logic ok;
   } sensor_rsp_type;

   logic clock = 0;
   logic reset;
   logic [grw_pkg::REQ_W-1:0] req_tdata;
   logic req_tvalid;
   logic req_tready;
   logic [grw_pkg::RSP_W-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic csr_wr_en;
   logic [0:0] csr_index;
   logic [grw_pkg::CFG_W-1:0] csr_wdata;

   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;
   bit sending_done = 0;

   grid_robot_world_sensors_unit dut (.*);

   // World model: keeps its own maps, robot, target and grid size and
   // queues the readings it predicts for each command transfer.
   class world_scoreboard;
      bit obst[MAX_COLS*MAX_ROWS];
      bit lmap[MAX_COLS*MAX_ROWS];
      int rcol, rrow, tcol, trow;
      logic [1:0] rhead;
      bit tvalid;
      int width_reg = 64, height_reg = 64;
      sensor_rsp_type pending[$];

      function int cols(); return width_reg < MAX_COLS ? width_reg : MAX_COLS; endfunction
      function int rows(); return height_reg < MAX_ROWS ? height_reg : MAX_ROWS; endfunction
      function bit on_grid(int c, int r);
         return c >= 0 && c < cols() && r >= 0 && r < rows();
      endfunction
      function bit blocked(int c, int r);
         return !on_grid(c, r) || obst[r*MAX_COLS + c];
      endfunction
      function int dcol(logic [1:0] h); return h == 1 ? 1 : (h == 3 ? -1 : 0); endfunction
      function int drow(logic [1:0] h); return h == 0 ? -1 : (h == 2 ? 1 : 0); endfunction

      function void set_reg(logic [0:0] idx, logic [6:0] v);
         if (idx == grw_pkg::CSR_GRID_WIDTH) width_reg = v; else height_reg = v;
      endfunction

      function void note_command(world_cmd_type c);
         sensor_rsp_type r;
         int sgn, nc, nr, k, fwd, lat, ddx, ddy;
         logic [1:0] h;
         r = '0;
         r.ok = 1;
         sgn = c.step_sign;
         if (sgn < -1) sgn = -1;
         case (c.cmd)
            grw_pkg::CMD_OBSTACLE:
               if (on_grid(c.pos_x, c.pos_y)) obst[c.pos_y*MAX_COLS + c.pos_x] = 1;
            grw_pkg::CMD_LINE:
               if (on_grid(c.pos_x, c.pos_y)) lmap[c.pos_y*MAX_COLS + c.pos_x] = 1;
            grw_pkg::CMD_ROBOT: begin
               rcol = c.pos_x; rrow = c.pos_y; rhead = c.heading_in;
            end
            grw_pkg::CMD_TARGET: begin
               tvalid = 1; tcol = c.pos_x; trow = c.pos_y;
            end
            grw_pkg::CMD_MOVE_TGT: if (tvalid) begin
               nc = tcol + c.move_dx; nr = trow + c.move_dy;
               if (!blocked(nc, nr)) begin
                  tcol = nc; trow = nr;
               end
            end
            grw_pkg::CMD_STEP: begin
               nc = rcol + dcol(rhead) * sgn;
               nr = rrow + drow(rhead) * sgn;
               if (blocked(nc, nr)) r.ok = 0;
               else begin
                  rcol = nc; rrow = nr;
               end
            end
            grw_pkg::CMD_ROTATE: rhead = rhead + c.turn_count[1:0];
            grw_pkg::CMD_RAYCAST: begin
               h = rhead;
               if (c.look_dir == grw_pkg::LOOK_LEFT) h = h + 2'd3;
               else if (c.look_dir == grw_pkg::LOOK_RIGHT) h = h + 2'd1;
               r.distance_cm = SCAN_MAX_CM;
               for (k = 1; k <= SCAN_MAX_CM / CELL_CM; k++)
                  if (blocked(rcol + dcol(h)*k, rrow + drow(h)*k)) begin
                     r.distance_cm = k * CELL_CM;
                     break;
                  end
            end
            grw_pkg::CMD_LINE_SNS: begin
               h = rhead + 2'd1;
               for (k = -2; k <= 2; k++) begin
                  nc = rcol + dcol(h)*k; nr = rrow + drow(h)*k;
                  if (on_grid(nc, nr) && lmap[nr*MAX_COLS + nc]) r.line_bits[k+2] = 1;
               end
            end
            grw_pkg::CMD_TGT_SNS: if (tvalid) begin
               ddx = tcol - rcol; ddy = trow - rrow;
               fwd = ddx*dcol(rhead) + ddy*drow(rhead);
               lat = ddx*dcol(rhead + 2'd1) + ddy*drow(rhead + 2'd1);
               if (fwd >= 0 && ddx*ddx + ddy*ddy <= SENSE_RANGE_I*SENSE_RANGE_I) begin
                  if (lat >= -1 && lat <= 1) begin
                     r.target_left = 1; r.target_right = 1;
                  end else if (lat > 1) r.target_right = 1;
                  else r.target_left = 1;
               end
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function int check_reading(sensor_rsp_type got);
         sensor_rsp_type exp_r;
         int bad;
         bad = 0;
         if (pending.size() == 0) begin
            $error("result transfer with nothing pending: %h", got);
            return 1;
         end
         exp_r = pending.pop_front();
         if (got.ok !== exp_r.ok) begin
            $error("ok expected %0d got %0d", exp_r.ok, got.ok); bad++;
         end
         if (got.distance_cm !== exp_r.distance_cm) begin
            $error("distance_cm expected %0d got %0d", exp_r.distance_cm, got.distance_cm);
            bad++;
         end
         if (got.line_bits !== exp_r.line_bits) begin
            $error("line_bits expected %b got %b", exp_r.line_bits, got.line_bits); bad++;
         end
         if (got.target_left !== exp_r.target_left) begin
            $error("target_left expected %0d got %0d", exp_r.target_left, got.target_left);
            bad++;
         end
         if (got.target_right !== exp_r.target_right) begin
            $error("target_right expected %0d got %0d", exp_r.target_right, got.target_right);
            bad++;
         end
         return bad;
      endfunction
   endclass

   world_scoreboard world = new();

   initial begin
      forever #10 clock = ~clock;
   end

   // Hold everything quiet, pulse reset once.
   initial begin
      reset = 1; req_tvalid = 0; req_tdata = '0; rsp_tready = 0;
      csr_wr_en = 0; csr_index = '0; csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 0;
   end

   // Receiver: random stalls plus an optional long hold-off counted here.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Check each result transfer against the oldest pending reading.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         errors += world.check_reading(rsp_tdata[17:0]);
   end

   // Offer one command and wait for its transfer; note it in the model.
   // Valid stays high into the next command unless the sender idles.
   task automatic send_command(world_cmd_type c);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tdata <= {2'b00, c.move_dy, c.move_dx, c.look_dir, c.turn_count, c.step_sign,
                    c.heading_in, c.pos_y, c.pos_x, c.cmd};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      world.note_command(c);
   endtask

   // Drop valid, wait for every pending reading, then let the slowest command drain.
   task automatic drain_results();
      req_tvalid <= 0;
      while (world.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [6:0] v);
      csr_index <= idx; csr_wdata <= v; csr_wr_en <= 1;
      @(posedge clock);
      csr_wr_en <= 0;
      world.set_reg(idx, v);
      @(posedge clock);
   endtask

   function automatic world_cmd_type any_command();
      world_cmd_type c;
      c = $urandom;
      c.move_dx = $urandom; c.move_dy = $urandom;
      return c;
   endfunction

   // Mostly in-grid activity with sensing; some wild coordinates and codes.
   function automatic world_cmd_type play_command();
      world_cmd_type c;
      int span_c, span_r;
      c = any_command();
      span_c = world.cols() + 1;
      span_r = world.rows() + 1;
      if ($urandom_range(9) != 0) begin
         c.cmd = $urandom_range(9);
         if (c.cmd == grw_pkg::CMD_OBSTACLE && $urandom_range(2) != 0)
            c.cmd = grw_pkg::CMD_STEP;
         c.pos_x = $signed($urandom_range(span_c)) - 1;
         c.pos_y = $signed($urandom_range(span_r)) - 1;
         c.move_dx = $signed($urandom_range(6)) - 3;
         c.move_dy = $signed($urandom_range(6)) - 3;
      end
      return c;
   endfunction

   task automatic run_phase(int n, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct; recv_stall_pct = stall_pct;
      repeat (n) send_command(play_command());
   endtask

   initial begin
      world_cmd_type c;
      int i;
      @(negedge reset);
      @(posedge clock);
      write_reg(grw_pkg::CSR_GRID_WIDTH, 7'd64);
      write_reg(grw_pkg::CSR_GRID_HEIGHT, 7'd64);

      // Directed: extremes, every command, each special case.
      c = '0; c.cmd = grw_pkg::CMD_RAYCAST; c.look_dir = 2'd1; send_command(c); // wall ahead
      c.look_dir = 2'd2; send_command(c);                    // long scan east, nothing hit
      c.look_dir = 2'd3; send_command(c);                    // look code 3 treated as ahead
      c = '0; c.cmd = grw_pkg::CMD_OBSTACLE; c.pos_x = 8'sd5; send_command(c);
      c.pos_x = -8'sd128; c.pos_y = 8'sd127; send_command(c);  // off grid, ignored
      c = '0; c.cmd = grw_pkg::CMD_LINE; c.pos_x = 8'sd2; c.pos_y = 8'sd3; send_command(c);
      c.pos_x = 8'sd63; c.pos_y = 8'sd63; send_command(c);
      c = '0; c.cmd = grw_pkg::CMD_ROBOT; c.pos_x = 8'sd2; c.pos_y = 8'sd3;
      c.heading_in = 2'd3;
      send_command(c);
      c = '0; c.cmd = grw_pkg::CMD_LINE_SNS; send_command(c);
      c = '0; c.cmd = grw_pkg::CMD_MOVE_TGT; c.move_dx = 8'sd1; send_command(c); // no target
      c = '0; c.cmd = grw_pkg::CMD_TGT_SNS; send_command(c);                  // no target
      c = '0; c.cmd = grw_pkg::CMD_TARGET; c.pos_x = 8'sd0; c.pos_y = 8'sd3; send_command(c);
      c = '0; c.cmd = grw_pkg::CMD_TGT_SNS; send_command(c);
      c = '0; c.cmd = grw_pkg::CMD_MOVE_TGT; c.move_dx = 8'sd127; c.move_dy = -8'sd128;
      send_command(c);
      c = '0; c.cmd = grw_pkg::CMD_STEP; c.step_sign = 2'sd1; send_command(c);
      c.step_sign = -2'sd2; send_command(c);                // saturates to backward
      c.step_sign = 2'sd0; send_command(c);
      c = '0; c.cmd = grw_pkg::CMD_ROTATE; c.turn_count = -4'sd8; send_command(c);
      c.turn_count = 4'sd7; send_command(c);
      c = '0; c.cmd = grw_pkg::CMD_ROBOT; c.pos_x = -8'sd128; c.pos_y = 8'sd127;
      send_command(c);
      c = '0; c.cmd = grw_pkg::CMD_STEP; c.step_sign = 2'sd0; send_command(c);
      c = '0; c.cmd = grw_pkg::CMD_RAYCAST; send_command(c);
      c = '1; send_command(c);                              // unused command code
      c = '0; c.cmd = 4'd10; send_command(c);
      drain_results();

      // Random phases across grid sizes, extremes included.
      run_phase(250, 0, 0);
      drain_results();
      write_reg(grw_pkg::CSR_GRID_WIDTH, 7'd1);
      write_reg(grw_pkg::CSR_GRID_HEIGHT, 7'd1);
      run_phase(150, 51, 0);
      drain_results();
      write_reg(grw_pkg::CSR_GRID_WIDTH, 7'd127);
      write_reg(grw_pkg::CSR_GRID_HEIGHT, 7'd8);
      run_phase(250, 0, 51);
      drain_results();
      write_reg(grw_pkg::CSR_GRID_WIDTH, 7'd12);
      write_reg(grw_pkg::CSR_GRID_HEIGHT, 7'd100);
      run_phase(250, 37, 37);
      // Long receiver hold-off while the sender keeps offering.
      hold_off = 300;
      run_phase(100, 0, 0);
      // Sender pauses until every reading is back.
      drain_results();
      write_reg(grw_pkg::CSR_GRID_WIDTH, 7'd9);
      write_reg(grw_pkg::CSR_GRID_HEIGHT, 7'd9);
      run_phase(350, 0, 0);
      drain_results();
      write_reg(grw_pkg::CSR_GRID_WIDTH, 7'd64);
      write_reg(grw_pkg::CSR_GRID_HEIGHT, 7'd64);
      for (i = 0; i < 4; i++) run_phase(100, (i & 1) ? 51 : 0, (i & 2) ? 51 : 0);
      drain_results();

      if (errors == 0) $display("PASS grid_robot_world_sensors_unit");
      else $display("FAIL grid_robot_world_sensors_unit");
      $finish;
   end

   // Watchdog, sized from the slowest legal run several times over.
   initial begin
      #40000000;
      $display("FAIL grid_robot_world_sensors_unit");
      $finish;
   end

endmodule
